// File: rtl/bcc_pkg.sv
`timescale 1ns / 1ps

package bcc_pkg;

    // Gesture codes carried on the result stream.
    typedef enum logic [1:0] {
        KIND_SHORT  = 2'd0,
        KIND_DOUBLE = 2'd1,
        KIND_TRIPLE = 2'd2,
        KIND_LONG   = 2'd3
    } t_kind;

    // Register indexes on the configuration write channel.
    localparam logic [1:0] CFG_SETTLE_COUNT = 2'd0;
    localparam logic [1:0] CFG_GAP_TICKS    = 2'd1;
    localparam logic [1:0] CFG_LONG_TICKS   = 2'd2;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [7:0]  SETTLE_COUNT_RESET = 8'd3;
    localparam logic [15:0] GAP_TICKS_RESET    = 16'd20;
    localparam logic [15:0] LONG_TICKS_RESET   = 16'd200;

    typedef struct packed {
        logic [7:0]  settle_count;
        logic [15:0] gap_ticks;
        logic [15:0] long_ticks;
    } t_cfg;

endpackage

// File: rtl/button_click_classifier_unit.sv
`timescale 1ns / 1ps

// Debounced button with click classification. Each input request is one scan
// tick carrying the raw level and an edge flag; a result request carries the
// recognized gesture (short, double, triple or long click) when a click
// sequence ends. One tick is taken every clock cycle unless stalled: a tick is
// held in the input register and updates the debounce and click state as it
// moves on, while the result register holds a finished gesture for the output
// side. A result is registered before it is presented. Throughput is set by the
// output register: the input stalls only when a result is waiting and the
// output side is not taking it. Configuration writes are taken every cycle and
// are meant to be made while the block is idle.
module button_click_classifier_unit
    import bcc_pkg::*;
#(
    parameter int TIMER_BITS  = 16,
    parameter int SETTLE_BITS = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [7:0]                s_axis_tdata,   // [0] raw_pressed, [1] edge_seen
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [7:0]                m_axis_tdata,   // [1:0] click_kind
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    t_cfg  r_cfg;
    logic  r_in_valid;
    logic  r_in_raw;
    logic  r_in_edge;
    logic  r_out_valid;
    t_kind r_out_kind;

    logic  fire;
    logic  res_valid;
    t_kind res_kind;

    // The held tick is processed once the result register can take its outcome.
    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_kind};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_count <= SETTLE_COUNT_RESET;
            r_cfg.gap_ticks    <= GAP_TICKS_RESET;
            r_cfg.long_ticks   <= LONG_TICKS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SETTLE_COUNT: r_cfg.settle_count <= i_cfg_data[7:0];
                CFG_GAP_TICKS:    r_cfg.gap_ticks    <= i_cfg_data;
                CFG_LONG_TICKS:   r_cfg.long_ticks   <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_raw  <= s_axis_tdata[0];
            r_in_edge <= s_axis_tdata[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= res_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && res_valid) begin
            r_out_kind <= res_kind;
        end
    end

    bcc_core #(
        .TIMER_BITS  (TIMER_BITS),
        .SETTLE_BITS (SETTLE_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_step      (fire),
        .i_raw       (r_in_raw),
        .i_edge      (r_in_edge),
        .o_res_valid (res_valid),
        .o_res_kind  (res_kind)
    );

endmodule

// File: rtl/bcc_core.sv
`timescale 1ns / 1ps

module bcc_core
    import bcc_pkg::*;
#(
    parameter int TIMER_BITS  = 16,
    parameter int SETTLE_BITS = 8
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_step,
    input  logic  i_raw,
    input  logic  i_edge,
    output logic  o_res_valid,
    output t_kind o_res_kind
);

    localparam int TW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
    localparam int SW = (SETTLE_BITS > 8) ? SETTLE_BITS : 8;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_WR1  = 3'd1,
        PH_WP1  = 3'd2,
        PH_WR2  = 3'd3,
        PH_WP2  = 3'd4,
        PH_WI   = 3'd5
    } t_phase;

    t_phase                 r_phase,       n_phase;
    logic [1:0]             r_cand,        n_cand;
    logic                   r_stable,      n_stable;
    logic [SETTLE_BITS-1:0] r_settle,      n_settle;
    logic [TIMER_BITS-1:0]  r_wait,        n_wait;
    logic                   r_armed,       n_armed;
    logic                   r_pend_valid,  n_pend_valid;
    t_kind                  r_pend_kind,   n_pend_kind;

    logic [TW-1:0]          gap_ext, long_ext;
    logic [TIMER_BITS-1:0]  gap_sat, long_sat;
    logic [SW-1:0]          settle_ext;
    logic [SETTLE_BITS-1:0] settle_sat;
    logic [7:0]             settle_req;

    logic                   do_step, timeout;
    t_phase                 cur_ph, nxt_ph;
    logic                   k_valid;
    t_kind                  k_kind;

    // Registers wider than their counters saturate on load.
    always_comb begin
        gap_ext    = TW'(i_cfg.gap_ticks);
        long_ext   = TW'(i_cfg.long_ticks);
        gap_sat    = (gap_ext > TW'({TIMER_BITS{1'b1}})) ? {TIMER_BITS{1'b1}}
                                                         : gap_ext[TIMER_BITS-1:0];
        long_sat   = (long_ext > TW'({TIMER_BITS{1'b1}})) ? {TIMER_BITS{1'b1}}
                                                          : long_ext[TIMER_BITS-1:0];
        settle_req = (i_cfg.settle_count == 8'd0) ? 8'd1 : i_cfg.settle_count;
        settle_ext = SW'(settle_req);
        settle_sat = (settle_ext > SW'({SETTLE_BITS{1'b1}})) ? {SETTLE_BITS{1'b1}}
                                                             : settle_ext[SETTLE_BITS-1:0];
    end

    always_comb begin
        n_phase      = r_phase;
        n_cand       = r_cand;
        n_stable     = r_stable;
        n_settle     = r_settle;
        n_wait       = r_wait;
        n_armed      = r_armed;
        n_pend_valid = r_pend_valid;
        n_pend_kind  = r_pend_kind;
        do_step      = 1'b0;
        timeout      = 1'b0;
        o_res_valid  = 1'b0;
        o_res_kind   = r_pend_kind;

        if (r_armed && (r_wait != '0)) begin
            n_wait = r_wait - 1'b1;
        end

        // A flagged edge or a new raw level restarts the debounce count.
        if (i_edge || (r_cand != {1'b0, i_raw})) begin
            n_cand   = {1'b0, i_raw};
            n_settle = settle_sat;
        end else if (r_settle != '0) begin
            n_settle = r_settle - 1'b1;
            if ((n_settle == '0) && (r_stable != r_cand[0])) begin
                do_step  = 1'b1;
                n_stable = r_cand[0];
            end
        end else if (r_armed && (n_wait == '0)) begin
            do_step = 1'b1;
            timeout = 1'b1;
        end

        unique case (r_phase)
            PH_WR1:  cur_ph = PH_WR1;
            PH_WP1:  cur_ph = PH_WP1;
            PH_WR2:  cur_ph = PH_WR2;
            PH_WP2:  cur_ph = PH_WP2;
            PH_WI:   cur_ph = PH_WI;
            default: cur_ph = PH_IDLE;
        endcase

        k_valid = 1'b0;
        k_kind  = KIND_SHORT;
        unique case (cur_ph)
            PH_WR1: begin
                nxt_ph  = timeout ? PH_WI : PH_WP1;
                k_valid = timeout;
                k_kind  = KIND_LONG;
            end
            PH_WP1: begin
                nxt_ph  = timeout ? PH_IDLE : PH_WR2;
                k_valid = timeout;
                k_kind  = KIND_SHORT;
            end
            PH_WR2: begin
                nxt_ph  = timeout ? PH_WI : PH_WP2;
                k_valid = timeout;
                k_kind  = KIND_DOUBLE;
            end
            PH_WP2: begin
                nxt_ph  = timeout ? PH_IDLE : PH_WI;
                k_valid = 1'b1;
                k_kind  = timeout ? KIND_DOUBLE : KIND_TRIPLE;
            end
            PH_WI: begin
                nxt_ph  = timeout ? PH_WI : PH_IDLE;
            end
            default: begin
                nxt_ph  = timeout ? PH_IDLE : PH_WR1;
            end
        endcase

        if (do_step) begin
            if (k_valid) begin
                n_pend_valid = 1'b1;
                n_pend_kind  = k_kind;
            end
            n_phase = nxt_ph;
            if (nxt_ph == PH_WR1) begin
                n_wait  = long_sat;
                n_armed = (i_cfg.long_ticks != 16'd0);
            end else begin
                n_wait  = gap_sat;
                n_armed = 1'b1;
            end
            // Back in idle the gesture is reported and the timer is dropped.
            if (nxt_ph == PH_IDLE) begin
                n_wait       = '0;
                n_armed      = 1'b0;
                o_res_valid  = n_pend_valid;
                o_res_kind   = n_pend_kind;
                n_pend_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_cand       <= 2'd2;
            r_stable     <= 1'b0;
            r_settle     <= '0;
            r_wait       <= '0;
            r_armed      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_pend_kind  <= KIND_SHORT;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_cand       <= n_cand;
            r_stable     <= n_stable;
            r_settle     <= n_settle;
            r_wait       <= n_wait;
            r_armed      <= n_armed;
            r_pend_valid <= n_pend_valid;
            r_pend_kind  <= n_pend_kind;
        end
    end

endmodule

// File: bench/button_click_classifier_unit_tb.sv
`timescale 1ns / 1ps

module button_click_classifier_unit_tb;
    import bcc_pkg::*;

    localparam int TAIL_CYCLES = 8;

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_WAIT_REL1   = 3'd1,
        PH_WAIT_PRESS1 = 3'd2,
        PH_WAIT_REL2   = 3'd3,
        PH_WAIT_PRESS2 = 3'd4,
        PH_WAIT_IDLE   = 3'd5
    } phase_e;

    typedef enum logic [1:0] {
        CHK_MODEL = 2'd0,
        CHK_NONE  = 2'd1,
        CHK_KIND  = 2'd2
    } row_check_e;

    typedef struct packed {
        bit         raw;
        bit         edge_flag;
        row_check_e how;
        t_kind      kind;
    } tick_row_t;

    // Triple click, reset settings: bar the first tick, each level is held for
    // settle count plus one tick; edge flags at tick two and the first change.
    localparam tick_row_t DIRECTED_TICKS [25] = '{
        '{1'b1, 1'b0, CHK_NONE,  KIND_SHORT},
        '{1'b1, 1'b1, CHK_NONE,  KIND_SHORT},
        '{1'b1, 1'b0, CHK_NONE,  KIND_SHORT},
        '{1'b1, 1'b0, CHK_NONE,  KIND_SHORT},
        '{1'b1, 1'b0, CHK_MODEL, KIND_SHORT},
        '{1'b0, 1'b1, CHK_MODEL, KIND_SHORT},
        '{1'b0, 1'b0, CHK_MODEL, KIND_SHORT},
        '{1'b0, 1'b0, CHK_MODEL, KIND_SHORT},
        '{1'b0, 1'b0, CHK_MODEL, KIND_SHORT},
        '{1'b1, 1'b0, CHK_MODEL, KIND_SHORT},
        '{1'b1, 1'b0, CHK_MODEL, KIND_SHORT},
        '{1'b1, 1'b0, CHK_MODEL, KIND_SHORT},
        '{1'b1, 1'b0, CHK_MODEL, KIND_SHORT},
        '{1'b0, 1'b0, CHK_MODEL, KIND_SHORT},
        '{1'b0, 1'b0, CHK_MODEL, KIND_SHORT},
        '{1'b0, 1'b0, CHK_MODEL, KIND_SHORT},
        '{1'b0, 1'b0, CHK_MODEL, KIND_SHORT},
        '{1'b1, 1'b0, CHK_MODEL, KIND_SHORT},
        '{1'b1, 1'b0, CHK_MODEL, KIND_SHORT},
        '{1'b1, 1'b0, CHK_MODEL, KIND_SHORT},
        '{1'b1, 1'b0, CHK_MODEL, KIND_SHORT},
        '{1'b0, 1'b0, CHK_MODEL, KIND_SHORT},
        '{1'b0, 1'b0, CHK_MODEL, KIND_SHORT},
        '{1'b0, 1'b0, CHK_MODEL, KIND_SHORT},
        '{1'b0, 1'b0, CHK_KIND,  KIND_TRIPLE}
    };

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'd0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       i_cfg_valid   = 1'b0;
    logic       o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data  = '0;

    // Predicted block state and register copies.
    phase_e     phase_now  = PH_IDLE;
    bit         cand_known = 1'b0;
    bit         cand_lvl   = 1'b0;
    bit         stable_lvl = 1'b0;
    bit [7:0]   settle_cnt = 8'd0;
    bit [15:0]  wait_cnt   = 16'd0;
    bit         wait_on    = 1'b0;
    bit         held_valid = 1'b0;
    t_kind      held_kind  = KIND_SHORT;
    bit [7:0]   reg_settle = SETTLE_COUNT_RESET;
    bit [15:0]  reg_gap    = GAP_TICKS_RESET;
    bit [15:0]  reg_long   = LONG_TICKS_RESET;

    t_kind      click_kinds_due [$];
    int         fail_count   = 0;
    int         results_seen = 0;
    int         ticks_sent   = 0;
    int         span_left    = 0;
    bit         calm         = 1'b0;

    button_click_classifier_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // One step of the click machine; returns 1 when a finished gesture leaves.
    function automatic bit advance_phase(bit timed_out, output t_kind kind);
        phase_e nxt;
        bit     has_kind;
        t_kind  k;
        bit     emitted;
        has_kind = 1'b0;
        k        = KIND_SHORT;
        kind     = KIND_SHORT;
        emitted  = 1'b0;
        case (phase_now)
            PH_WAIT_REL1: begin
                nxt = timed_out ? PH_WAIT_IDLE : PH_WAIT_PRESS1;
                if (timed_out) begin
                    has_kind = 1'b1;
                    k        = KIND_LONG;
                end
            end
            PH_WAIT_PRESS1: begin
                nxt = timed_out ? PH_IDLE : PH_WAIT_REL2;
                if (timed_out) begin
                    has_kind = 1'b1;
                    k        = KIND_SHORT;
                end
            end
            PH_WAIT_REL2: begin
                nxt = timed_out ? PH_WAIT_IDLE : PH_WAIT_PRESS2;
                if (timed_out) begin
                    has_kind = 1'b1;
                    k        = KIND_DOUBLE;
                end
            end
            PH_WAIT_PRESS2: begin
                nxt      = timed_out ? PH_IDLE : PH_WAIT_IDLE;
                has_kind = 1'b1;
                k        = timed_out ? KIND_DOUBLE : KIND_TRIPLE;
            end
            PH_WAIT_IDLE: begin
                nxt = timed_out ? PH_WAIT_IDLE : PH_IDLE;
            end
            default: begin
                nxt = timed_out ? PH_IDLE : PH_WAIT_REL1;
            end
        endcase
        if (has_kind) begin
            held_kind  = k;
            held_valid = 1'b1;
        end
        phase_now = nxt;
        if (nxt == PH_WAIT_REL1) begin
            wait_cnt = reg_long;
            wait_on  = (reg_long != 16'd0);
        end else begin
            wait_cnt = reg_gap;
            wait_on  = 1'b1;
        end
        if (nxt == PH_IDLE) begin
            wait_on    = 1'b0;
            wait_cnt   = 16'd0;
            emitted    = held_valid;
            kind       = held_kind;
            held_valid = 1'b0;
        end
        return emitted;
    endfunction

    function automatic bit classify_tick(bit raw, bit edge_flag, output t_kind kind);
        bit emitted;
        emitted = 1'b0;
        kind    = KIND_SHORT;
        if (wait_on && wait_cnt != 16'd0)
            wait_cnt = wait_cnt - 16'd1;
        if (edge_flag || !cand_known || raw != cand_lvl) begin
            cand_known = 1'b1;
            cand_lvl   = raw;
            settle_cnt = (reg_settle == 8'd0) ? 8'd1 : reg_settle;
        end else if (settle_cnt != 8'd0) begin
            settle_cnt = settle_cnt - 8'd1;
            if (settle_cnt == 8'd0 && stable_lvl != cand_lvl) begin
                emitted    = advance_phase(1'b0, kind);
                stable_lvl = cand_lvl;
            end
        end else if (wait_on && wait_cnt == 16'd0) begin
            // A timeout is only taken once the level has settled.
            emitted = advance_phase(1'b1, kind);
        end
        return emitted;
    endfunction

    function automatic int sender_idle();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic send_tick(bit raw, bit edge_flag, row_check_e how, t_kind given);
        int    idle;
        bit    emitted;
        t_kind kind;
        idle = sender_idle();
        if (idle > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, edge_flag, raw};
        do @(posedge i_clk); while (!s_axis_tready);
        ticks_sent++;
        emitted = classify_tick(raw, edge_flag, kind);
        case (how)
            CHK_MODEL: begin
                if (emitted)
                    click_kinds_due.push_back(kind);
            end
            CHK_KIND: begin
                click_kinds_due.push_back(given);
            end
            default: begin
            end
        endcase
    endtask

    task automatic tick(bit raw, bit edge_flag);
        send_tick(raw, edge_flag, CHK_MODEL, KIND_SHORT);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] word);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= word;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SETTLE_COUNT: reg_settle = word[7:0];
            CFG_GAP_TICKS:    reg_gap    = word;
            CFG_LONG_TICKS:   reg_long   = word;
            default: begin
            end
        endcase
    endtask

    // Stop sending and let every outstanding result and in-flight tick clear.
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (click_kinds_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic hold_level(bit level, int n, bit clean);
        int i;
        int s;
        s = (reg_settle == 8'd0) ? 1 : int'(reg_settle);
        for (i = 0; i < n; i++) begin
            // A blip shorter than the settle count must not reach the machine.
            if (!clean && i > 0 && s > 1 && $urandom_range(0, 29) == 0)
                repeat ($urandom_range(1, s - 1)) tick(!level, 1'b0);
            if (i == 0)
                tick(level, $urandom_range(0, 1));
            else
                tick(level, !clean && $urandom_range(0, 24) == 0);
        end
    endtask

    // One click sequence with random timing around the configured limits, or
    // now and then a burst of noise.
    task automatic play_gesture(int max_clicks, bit clean);
        int s;
        int clicks;
        int n;
        int span;
        int extra;
        bit go_long;
        bit big_gap;
        s       = (reg_settle == 8'd0) ? 1 : int'(reg_settle);
        big_gap = (reg_gap > 16'd1000);
        if (!clean && $urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(3, 15)) tick($urandom_range(0, 1), $urandom_range(0, 1));
        end else begin
            // With a huge gap only a triple click gets back to idle.
            clicks  = big_gap ? 3 : $urandom_range(1, max_clicks);
            go_long = reg_long != 16'd0 && reg_long <= 16'd300 && $urandom_range(0, 3) == 0;
            span    = big_gap ? 3 : int'(reg_gap) + 2;
            for (n = 0; n < clicks; n++) begin
                extra = (go_long && n == clicks - 1) ? int'(reg_long) : 0;
                hold_level(1'b1, s + 1 + extra + $urandom_range(0, 3), clean);
                if (n < clicks - 1)
                    hold_level(1'b0, s + 1 + $urandom_range(0, span), clean);
            end
            hold_level(1'b0, s + 4 + (big_gap ? 0 : int'(reg_gap)), clean);
        end
    endtask

    task automatic run_phase(logic [15:0] settle_w, logic [15:0] gap_w, logic [15:0] long_w,
                             int quota, int max_clicks, bit clean, int min_results);
        int start;
        wait_quiet();
        write_reg(CFG_SETTLE_COUNT, settle_w);
        write_reg(CFG_GAP_TICKS, gap_w);
        write_reg(CFG_LONG_TICKS, long_w);
        i_cfg_valid <= 1'b0;
        start = ticks_sent;
        while (ticks_sent - start < quota || results_seen < min_results)
            play_gesture(max_clicks, clean);
    endtask

    // Output side: bursts of ready, short stalls and now and then a long one.
    always @(posedge i_clk) begin
        if (span_left > 0) begin
            span_left <= span_left - 1;
        end else if (calm || $urandom_range(0, 2) != 0) begin
            m_axis_tready <= 1'b1;
            span_left     <= $urandom_range(0, 15);
        end else begin
            m_axis_tready <= 1'b0;
            span_left     <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                         : $urandom_range(0, 2);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_kind want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (click_kinds_due.size() == 0) begin
                $error("click_kind: expected no result, actual %0d", m_axis_tdata[1:0]);
                fail_count++;
            end else begin
                want = click_kinds_due.pop_front();
                if (m_axis_tdata[1:0] != want) begin
                    $error("click_kind: expected %0d, actual %0d", want, m_axis_tdata[1:0]);
                    fail_count++;
                end
            end
        end
    end

    initial begin : stimulus
        int r;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < 25; r++)
            send_tick(DIRECTED_TICKS[r].raw, DIRECTED_TICKS[r].edge_flag,
                      DIRECTED_TICKS[r].how, DIRECTED_TICKS[r].kind);

        run_phase(16'd2, 16'd6, 16'd12, 120, 3, 1'b0, 0);
        // Zero settle count, zero gap and long press disabled, with no idling.
        calm = 1'b1;
        run_phase(16'd0, 16'd0, 16'd0, 120, 3, 1'b0, 0);
        calm = 1'b0;
        run_phase(16'd1, 16'd1, 16'd1, 100, 3, 1'b0, 0);
        run_phase(16'd3, 16'd20, 16'd200, 60, 3, 1'b0, 0);
        run_phase(16'd255, 16'd3, 16'hffff, 1, 1, 1'b1, 0);
        // Upper data bits of the settle write are dropped by the 8-bit register.
        run_phase(16'hff01, 16'hffff, 16'd0, 60, 3, 1'b1, 0);
        run_phase(16'd4, 16'd10, 16'd30, 80, 3, 1'b0, 40);

        wait_quiet();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
